>>> design/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types and constants for the signed decimal field formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // digits needed for the largest 64-bit magnitude
  localparam int NUM_DIGITS = 20;

  // default field clamp
  localparam int MAX_FIELD_DEF = 64;

  // size mode codes
  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_8  = 2'd1;
  localparam logic [1:0] SIZE_16 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // bit positions in format_flags
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ZERO  = 4;

  // ascii codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // operation applied to every digit cell in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

endpackage

`default_nettype wire

>>> design/signed_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// printf style signed decimal conversion with sign, padding and a char count
// ----------------------------------------------------------------------------
// sequence: accept in IDLE, then CONVERT over all 8, 16, 32 or 64 bits by
//   size mode, one magnitude bit per cycle through the bcd cell chain, then
//   NORMALIZE to drop leading zeros (nd = significant digits), then EMIT, one
//   character per cycle out of the output register unless out_ready stalls it
// a new item is taken only after the field's last character is registered out
// reset: state, character count and output valid cleared; digit cells on accept
`default_nettype none

module signed_decimal_field_formatter #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  input  wire logic [1:0]  size_mode,
  input  wire logic [4:0]  format_flags,
  input  wire logic [6:0]  pad_width,
  // result item
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       char_out,
  output logic             last_char,
  output logic [31:0]      total_written
);

  localparam int         ND       = sdf_pkg::NUM_DIGITS;
  localparam logic [6:0] MaxWidth = 7'(MAX_FIELD);

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    NORMALIZE,
    EMIT
  } state_t;

  state_t      state;

  // item registers
  logic [63:0] mag;          // magnitude, msb aligned, shifted out msb first
  logic [6:0]  bits_left;
  logic [4:0]  nd;           // significant digits left in the chain
  logic        has_sign;
  logic [7:0]  sign_char;
  logic        left_just;
  logic        zero_pad;
  logic [6:0]  width_c;
  // field layout: spaces | sign | zeros | digits | trailing spaces
  logic [6:0]  b1, b2, b3, b4, last_pos;
  logic [6:0]  k;            // position of the next character
  logic [31:0] char_count;

  // accept-side decode
  logic [63:0] x_ext;
  logic [63:0] mag_abs;
  logic [63:0] mag_aligned;
  logic [6:0]  size_bits;
  logic        neg;

  always_comb begin
    unique case (size_mode)
      sdf_pkg::SIZE_8: begin
        x_ext     = {{56{value[7]}}, value[7:0]};
        size_bits = 7'd8;
      end
      sdf_pkg::SIZE_16: begin
        x_ext     = {{48{value[15]}}, value[15:0]};
        size_bits = 7'd16;
      end
      sdf_pkg::SIZE_32: begin
        x_ext     = {{32{value[31]}}, value[31:0]};
        size_bits = 7'd32;
      end
      default: begin
        x_ext     = value;
        size_bits = 7'd64;
      end
    endcase
    neg     = x_ext[63];
    // most negative value wraps to itself, read as unsigned it is right
    mag_abs = neg ? 64'(~x_ext + 64'd1) : x_ext;
    // a magnitude always fits the chosen size, so align it to the top
    unique case (size_mode)
      sdf_pkg::SIZE_8:  mag_aligned = {mag_abs[7:0], 56'd0};
      sdf_pkg::SIZE_16: mag_aligned = {mag_abs[15:0], 48'd0};
      sdf_pkg::SIZE_32: mag_aligned = {mag_abs[31:0], 32'd0};
      default:          mag_aligned = mag_abs;
    endcase
  end

  // digit cell chain, index 0 is the least significant digit
  sdf_pkg::cell_op_t cell_op;
  logic [3:0]        digit [ND];
  logic [ND-1:0]     carry;          // carry[i] feeds cell i

  assign carry[0] = mag[63];

  for (genvar i = 0; i < ND; i++) begin : g_cell
    if (i < ND - 1) begin : g_mid
      sdf_bcd_cell u_cell (
        .clk      (clk),
        .op       (cell_op),
        .bit_in   (carry[i]),
        .digit_in ((i == 0) ? 4'd0 : digit[(i == 0) ? 0 : i - 1]),
        .bit_out  (carry[i+1]),
        .digit    (digit[i])
      );
    end else begin : g_top
      // magnitude never overflows the chain, top carry is always zero
      sdf_bcd_cell u_cell (
        .clk      (clk),
        .op       (cell_op),
        .bit_in   (carry[i]),
        .digit_in (digit[i-1]),
        .bit_out  (),
        .digit    (digit[i])
      );
    end
  end

  logic [3:0] top_digit;
  assign top_digit = digit[ND-1];

  // output side
  logic       advance;
  logic       in_digits;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       norm_shift;

  assign in_ready      = (state == IDLE);
  assign advance       = !out_valid || out_ready;
  assign total_written = char_count;
  assign norm_shift    = (top_digit == 4'd0) && (nd > 5'd1);

  always_comb begin
    in_digits = (k >= b3) && (k < b4);
    if (k < b1) begin
      emit_char = sdf_pkg::CHAR_SPACE;
    end else if (k < b2) begin
      emit_char = sign_char;
    end else if (k < b3) begin
      emit_char = sdf_pkg::CHAR_ZERO;
    end else if (k < b4) begin
      emit_char = sdf_pkg::CHAR_ZERO + {4'd0, top_digit};
    end else begin
      emit_char = sdf_pkg::CHAR_SPACE;
    end
    emit_last = (k == last_pos);
  end

  always_comb begin
    cell_op = sdf_pkg::CELL_HOLD;
    unique case (state)
      IDLE:      if (in_valid) cell_op = sdf_pkg::CELL_CLEAR;
      CONVERT:   cell_op = sdf_pkg::CELL_DABBLE;
      NORMALIZE: if (norm_shift) cell_op = sdf_pkg::CELL_SHIFT;
      EMIT:      if (advance && in_digits) cell_op = sdf_pkg::CELL_SHIFT;
      default:   cell_op = sdf_pkg::CELL_HOLD;
    endcase
  end

  // layout arithmetic, used in the last normalise cycle
  logic [6:0] len, pad, lead, zeros, trail;
  logic [6:0] b1_next, b2_next, b3_next, b4_next;

  always_comb begin
    len     = 7'(nd) + {6'd0, has_sign};
    pad     = (width_c > len) ? 7'(width_c - len) : 7'd0;
    lead    = (!left_just && !zero_pad) ? pad : 7'd0;
    zeros   = (!left_just && zero_pad) ? pad : 7'd0;
    trail   = left_just ? pad : 7'd0;
    b1_next = lead;
    b2_next = 7'(lead + {6'd0, has_sign});
    b3_next = 7'(b2_next + zeros);
    b4_next = 7'(b3_next + 7'(nd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      char_count <= 32'd0;
    end else begin
      // while emitting, a taken item is always replaced by the next one
      if (state != EMIT && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            mag       <= mag_aligned;
            bits_left <= size_bits;
            has_sign  <= neg || format_flags[sdf_pkg::FLAG_PLUS]
                             || format_flags[sdf_pkg::FLAG_SPACE];
            // minus first, then plus wins over space
            sign_char <= neg ? sdf_pkg::CHAR_MINUS
                       : format_flags[sdf_pkg::FLAG_PLUS] ? sdf_pkg::CHAR_PLUS
                       : sdf_pkg::CHAR_SPACE;
            left_just <= format_flags[sdf_pkg::FLAG_LEFT];
            zero_pad  <= format_flags[sdf_pkg::FLAG_ZERO];
            width_c   <= (pad_width > MaxWidth) ? MaxWidth : pad_width;
            state     <= CONVERT;
          end
        end
        CONVERT: begin
          mag       <= {mag[62:0], 1'b0};
          bits_left <= 7'(bits_left - 7'd1);
          if (bits_left == 7'd1) begin
            nd    <= 5'(ND);
            state <= NORMALIZE;
          end
        end
        NORMALIZE: begin
          if (norm_shift) begin
            nd <= 5'(nd - 5'd1);
          end else begin
            b1       <= b1_next;
            b2       <= b2_next;
            b3       <= b3_next;
            b4       <= b4_next;
            last_pos <= 7'(b4_next + trail - 7'd1);
            k        <= 7'd0;
            state    <= EMIT;
          end
        end
        EMIT: begin
          if (advance) begin
            out_valid  <= 1'b1;
            char_out   <= emit_char;
            last_char  <= emit_last;
            char_count <= 32'(char_count + 32'd1);
            k          <= 7'(k + 7'd1);
            if (emit_last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/sdf_bcd_cell.sv
// ----------------------------------------------------------------------------
// sdf_bcd_cell
// one bcd digit of the conversion chain: add-3 and shift, or digit shift
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_bcd_cell (
  input  wire logic             clk,
  input  wire sdf_pkg::cell_op_t op,
  input  wire logic             bit_in,
  input  wire logic [3:0]       digit_in,
  output logic                  bit_out,
  output logic [3:0]            digit
);

  logic [3:0] adj;

  // correct before shifting so the digit stays decimal
  always_comb begin
    adj     = (digit >= 4'd5) ? 4'(digit + 4'd3) : digit;
    bit_out = adj[3];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      sdf_pkg::CELL_HOLD:   digit <= digit;
      sdf_pkg::CELL_CLEAR:  digit <= 4'd0;
      sdf_pkg::CELL_DABBLE: digit <= {adj[2:0], bit_in};
      sdf_pkg::CELL_SHIFT:  digit <= digit_in;
      default:              digit <= digit;
    endcase
  end

endmodule

`default_nettype wire

>>> design/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_checker
// port level checks for the signed decimal field formatter
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  char_out,
  input wire logic        last_char,
  input wire logic [31:0] total_written
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_char))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // no new item before the field's last character is out
  a_field_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_char |-> !in_ready)
    else $error("input ready in the middle of a field");

  // count only moves by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (total_written != $past(total_written))
      |-> total_written == 32'($past(total_written) + 32'd1))
    else $error("character count jumped");

  // count frozen while a result is stalled
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(total_written))
    else $error("character count moved while stalled");

endmodule

bind signed_decimal_field_formatter sdf_checker u_sdf_checker (.*);

`default_nettype wire
